### rtl/core/fcp_pkg.sv
`timescale 1ns / 1ps

package fcp_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 16;
	localparam int unsigned NUM_FIELDS      = 3;
	localparam int unsigned OUT_WIDTH       = 16;
	localparam int unsigned M_TDATA_WIDTH   = 56;

	localparam logic [7:0] CHAR_START    = 8'h21; // '!'
	localparam logic [7:0] CHAR_TRIANGLE = 8'h54; // 'T'
	localparam logic [7:0] CHAR_SINE     = 8'h53; // 'S'
	localparam logic [7:0] CHAR_SQUARE   = 8'h43; // 'C'
	localparam logic [7:0] CHAR_SAWTOOTH = 8'h44; // 'D'
	localparam logic [7:0] CHAR_PLUS     = 8'h2B;
	localparam logic [7:0] CHAR_MINUS    = 8'h2D;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_NINE     = 8'h39;
	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_TAB      = 8'h09;
	localparam logic [7:0] CHAR_CR       = 8'h0D;

	localparam logic [7:0] POS_START    = 8'd0;
	localparam logic [7:0] POS_WAVEFORM = 8'd3;
	localparam logic [7:0] POS_MAX      = 8'd255;
	localparam logic [7:0] POS_FREQ     = 8'd6;
	localparam logic [7:0] POS_AMPL     = 8'd12;
	localparam logic [7:0] POS_OFFS     = 8'd19;

	localparam logic [1:0] WAVE_TRIANGLE = 2'd0;
	localparam logic [1:0] WAVE_SINE     = 2'd1;
	localparam logic [1:0] WAVE_SQUARE   = 2'd2;
	localparam logic [1:0] WAVE_SAWTOOTH = 2'd3;

	typedef enum logic [3:0] {
		PH_WAIT   = 4'b0001,
		PH_LEAD   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// one byte moving from the input register through the parsers
	typedef struct packed {
		logic       step;
		logic       clear;
		logic [7:0] data;
		logic [7:0] pos;
	} step_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

endpackage

### rtl/core/fcp_field_parser.sv
`timescale 1ns / 1ps

module fcp_field_parser #(
	parameter int unsigned VALUE_WIDTH = fcp_pkg::VALUE_WIDTH_DEF,
	parameter logic [7:0]  START_POS   = fcp_pkg::POS_FREQ
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fcp_pkg::step_t         st,
	output logic [VALUE_WIDTH-1:0] value
);

	fcp_pkg::phase_t        phase_q, phase_eff, phase_nxt;
	logic                   neg_q, neg_nxt;
	logic [VALUE_WIDTH-1:0] acc_q, acc_nxt;
	logic [VALUE_WIDTH-1:0] digit;
	logic                   is_dig;

	assign is_dig = fcp_pkg::is_digit(st.data);
	assign digit  = VALUE_WIDTH'(st.data[3:0]);

	always_comb begin
		phase_eff = phase_q;
		if (phase_q == fcp_pkg::PH_WAIT && st.pos == START_POS) begin
			phase_eff = fcp_pkg::PH_LEAD;
		end
		phase_nxt = phase_eff;
		neg_nxt   = neg_q;
		acc_nxt   = acc_q;
		unique case (phase_eff)
			fcp_pkg::PH_LEAD: begin
				if (fcp_pkg::is_space(st.data)) begin
					phase_nxt = fcp_pkg::PH_LEAD;
				end else if (st.data == fcp_pkg::CHAR_PLUS || st.data == fcp_pkg::CHAR_MINUS) begin
					phase_nxt = fcp_pkg::PH_DIGITS;
					if (st.data == fcp_pkg::CHAR_MINUS) begin
						neg_nxt = 1'b1;
					end
				end else if (is_dig) begin
					phase_nxt = fcp_pkg::PH_DIGITS;
					acc_nxt   = digit;
				end else begin
					phase_nxt = fcp_pkg::PH_DONE;
				end
			end
			fcp_pkg::PH_DIGITS: begin
				if (is_dig) begin
					// times ten as two shifts, wraps at the value width
					acc_nxt = (acc_q << 3) + (acc_q << 1) + digit;
				end else begin
					phase_nxt = fcp_pkg::PH_DONE;
				end
			end
			default: begin
				phase_nxt = phase_eff;
			end
		endcase
	end

	assign value = neg_nxt ? (~acc_nxt + VALUE_WIDTH'(1)) : acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fcp_pkg::PH_WAIT;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (st.step) begin
			if (st.clear) begin
				phase_q <= fcp_pkg::PH_WAIT;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_nxt;
				neg_q   <= neg_nxt;
				acc_q   <= acc_nxt;
			end
		end
	end

endmodule

### rtl/core/fixed_field_command_parser.sv
`timescale 1ns / 1ps
// a byte is taken into the input register; for the last byte the result then goes into the result register on m_tdata
// throughput: one byte per cycle; the input register and the result register decouple
// the two sides, so the input only stalls when a finished result is held by m_tready low
// reset: arst_n clears position, parsers, stored parameters and both valid flags
// a result is sent only for the byte with s_tlast set

module fixed_field_command_parser #(
	parameter int unsigned VALUE_WIDTH = fcp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata, // rx_byte
	input  logic                              s_tlast, // end_of_message
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// message_valid, remote_changed, save_request, waveform[1:0], frequency_value[15:0],
	// amplitude_value[15:0], offset_value[15:0], zero fill
	output logic [fcp_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

	logic                   valid_s1, last_s1;
	logic [7:0]             byte_s1;
	logic [7:0]             pos_q;
	logic                   start_ok_q, start_eff;
	logic [1:0]             wave_pend_q, wave_eff;
	logic [1:0]             wave_store_q;
	logic [VALUE_WIDTH-1:0] freq_store_q, ampl_store_q, offs_store_q;
	logic                   saved_q;
	logic [VALUE_WIDTH-1:0] freq_val, ampl_val, offs_val;
	logic                   out_free, step, finish, same;
	logic                   m_tvalid_q;
	logic [fcp_pkg::M_TDATA_WIDTH-1:0] m_tdata_q, result;
	fcp_pkg::step_t         st;

	assign out_free = !m_tvalid_q || m_tready;
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign finish   = step && last_s1;
	assign s_tready = !valid_s1 || step;

	assign st.step  = step;
	assign st.clear = last_s1;
	assign st.data  = byte_s1;
	assign st.pos   = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// start marker and waveform letter, as seen after the current byte
	always_comb begin
		start_eff = start_ok_q;
		wave_eff  = wave_pend_q;
		if (pos_q == fcp_pkg::POS_START) begin
			start_eff = (byte_s1 == fcp_pkg::CHAR_START);
			wave_eff  = wave_store_q;
		end
		if (pos_q == fcp_pkg::POS_WAVEFORM) begin
			unique case (byte_s1)
				fcp_pkg::CHAR_TRIANGLE: wave_eff = fcp_pkg::WAVE_TRIANGLE;
				fcp_pkg::CHAR_SINE:     wave_eff = fcp_pkg::WAVE_SINE;
				fcp_pkg::CHAR_SQUARE:   wave_eff = fcp_pkg::WAVE_SQUARE;
				fcp_pkg::CHAR_SAWTOOTH: wave_eff = fcp_pkg::WAVE_SAWTOOTH;
				default:                wave_eff = wave_pend_q;
			endcase
		end
	end

	fcp_field_parser #(.VALUE_WIDTH(VALUE_WIDTH), .START_POS(fcp_pkg::POS_FREQ)) u_freq (
		.clk(clk), .arst_n(arst_n), .st(st), .value(freq_val)
	);
	fcp_field_parser #(.VALUE_WIDTH(VALUE_WIDTH), .START_POS(fcp_pkg::POS_AMPL)) u_ampl (
		.clk(clk), .arst_n(arst_n), .st(st), .value(ampl_val)
	);
	fcp_field_parser #(.VALUE_WIDTH(VALUE_WIDTH), .START_POS(fcp_pkg::POS_OFFS)) u_offs (
		.clk(clk), .arst_n(arst_n), .st(st), .value(offs_val)
	);

	assign same = (freq_val == freq_store_q) && (ampl_val == ampl_store_q) &&
	              (offs_val == offs_store_q) && (wave_eff == wave_store_q) && saved_q;

	always_comb begin
		result = '0;
		if (start_eff) begin
			result[0]     = 1'b1;
			result[1]     = !same;
			result[2]     = 1'b1;
			result[4:3]   = wave_eff;
			result[20:5]  = fcp_pkg::OUT_WIDTH'($signed(freq_val));
			result[36:21] = fcp_pkg::OUT_WIDTH'($signed(ampl_val));
			result[52:37] = fcp_pkg::OUT_WIDTH'($signed(offs_val));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			start_ok_q  <= 1'b0;
			wave_pend_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				pos_q       <= '0;
				start_ok_q  <= 1'b0;
				wave_pend_q <= '0;
			end else begin
				if (pos_q != fcp_pkg::POS_MAX) begin
					pos_q <= pos_q + 8'd1;
				end
				start_ok_q  <= start_eff;
				wave_pend_q <= wave_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_store_q <= '0;
			freq_store_q <= '0;
			ampl_store_q <= '0;
			offs_store_q <= '0;
			saved_q      <= 1'b0;
		end else if (finish && start_eff) begin
			wave_store_q <= wave_eff;
			freq_store_q <= freq_val;
			ampl_store_q <= ampl_val;
			offs_store_q <= offs_val;
			saved_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### rtl/core/fcp_checker.sv
`timescale 1ns / 1ps

module fcp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [fcp_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// save request follows message valid
	a_save: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2] == m_tdata[0])
		else $error("save_request differs from message_valid");

	// rejected message carries nothing
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata == '0)
		else $error("rejected message has nonzero fields");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:53] == 3'b000)
		else $error("fill bits not zero");

endmodule

bind fixed_field_command_parser fcp_checker u_fcp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import fcp_pkg::*;

	typedef struct packed {
		logic [2:0]  fill;
		logic [15:0] offs;
		logic [15:0] ampl;
		logic [15:0] freq;
		logic [1:0]  wave;
		logic        save;
		logic        changed;
		logic        ok;
	} cmd_result_t;

	localparam logic [7:0] FIELD_POS [NUM_FIELDS] = '{POS_FREQ, POS_AMPL, POS_OFFS};
	localparam int         NUM_DIR             = 17;
	localparam int         PHASE_BYTES         = 260;
	localparam int         SEND_IDLE [4]       = '{0, 66, 0, 11};
	localparam int         RECV_STALL [4]      = '{0, 0, 66, 11};

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [7:0]               s_tdata;
	logic                     s_tlast;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [M_TDATA_WIDTH-1:0] m_tdata;

	// parser state as the block should hold it
	logic [7:0]  msg_pos;
	logic        msg_started;
	logic [1:0]  msg_wave;
	logic [15:0] field_acc [NUM_FIELDS];
	phase_t      field_ph [NUM_FIELDS];
	logic        field_neg [NUM_FIELDS];
	logic [1:0]  stored_wave;
	logic [15:0] stored_freq;
	logic [15:0] stored_ampl;
	logic [15:0] stored_offs;
	logic        saved_once;

	cmd_result_t expected_results [$];
	logic [7:0]  cmd_bytes [$];
	logic [7:0]  prev_cmd [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int sent_bytes     = 0;
	int sent_cmds      = 0;
	int error_cnt      = 0;
	int checked_cnt    = 0;
	int unchanged_cnt  = 0;
	int rejected_cnt   = 0;

	function automatic cmd_result_t make_result(input logic ok, input logic changed,
			input logic [1:0] wave, input logic [15:0] freq, input logic [15:0] ampl,
			input logic [15:0] offs);
		cmd_result_t r;
		r         = '0;
		r.ok      = ok;
		r.changed = changed;
		r.save    = ok;
		r.wave    = wave;
		r.freq    = freq;
		r.ampl    = ampl;
		r.offs    = offs;
		return r;
	endfunction

	string dir_text [NUM_DIR] = '{
		"?",
		"!",
		"!",
		"!W:C  32767 -32768 32767",
		"!W:T  0     0      0",
		"!W:S  +123  -45    +6",
		"!W:X  10    20     30",
		"!W",
		"!W:D",
		"!W:T \t\n\013\014 5 \r\n\t 17 \r  \t 800",
		"!W:S  -     +      -",
		"!W:C  99999999999999999999999",
		"!W:D  /7    :8     \0379",
		"!W:T  \0107    \0168     \0409",
		"#W:C  12    34     56",
		"!W:D  123   456    789",
		"!W:D  123   456    789"
	};
	bit dir_typed [NUM_DIR] = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0};
	cmd_result_t dir_res [NUM_DIR] = '{
		'0,
		make_result(1'b1, 1'b1, WAVE_TRIANGLE, 16'h0000, 16'h0000, 16'h0000),
		make_result(1'b1, 1'b0, WAVE_TRIANGLE, 16'h0000, 16'h0000, 16'h0000),
		make_result(1'b1, 1'b1, WAVE_SQUARE, 16'h7FFF, 16'h8000, 16'h7FFF),
		make_result(1'b1, 1'b1, WAVE_TRIANGLE, 16'h0000, 16'h0000, 16'h0000),
		'0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0
	};

	fixed_field_command_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic clear_message();
		msg_pos     = '0;
		msg_started = 1'b0;
		msg_wave    = WAVE_TRIANGLE;
		for (int f = 0; f < NUM_FIELDS; f++) begin
			field_acc[f] = '0;
			field_ph[f]  = PH_WAIT;
			field_neg[f] = 1'b0;
		end
	endtask

	// advance the parser by one byte; a result comes only on the last byte
	task automatic parse_rx_byte(input logic [7:0] c, input logic last, output bit has_res,
			output cmd_result_t res);
		phase_t      ph;
		logic        is_ws;
		logic        is_dig;
		logic [15:0] val [NUM_FIELDS];
		logic        same;
		is_ws   = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
		is_dig  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		has_res = 1'b0;
		res     = '0;
		if (msg_pos == POS_START) begin
			msg_started = (c == CHAR_START);
			msg_wave    = stored_wave;
		end
		if (msg_pos == POS_WAVEFORM) begin
			case (c)
				CHAR_TRIANGLE: msg_wave = WAVE_TRIANGLE;
				CHAR_SINE:     msg_wave = WAVE_SINE;
				CHAR_SQUARE:   msg_wave = WAVE_SQUARE;
				CHAR_SAWTOOTH: msg_wave = WAVE_SAWTOOTH;
				default:       msg_wave = msg_wave;
			endcase
		end
		for (int f = 0; f < NUM_FIELDS; f++) begin
			ph = field_ph[f];
			if (ph == PH_WAIT && msg_pos == FIELD_POS[f])
				ph = PH_LEAD;
			if (ph == PH_LEAD) begin
				if (c == CHAR_PLUS || c == CHAR_MINUS) begin
					field_neg[f] = (c == CHAR_MINUS);
					ph           = PH_DIGITS;
				end else if (is_dig) begin
					field_acc[f] = 16'(c - CHAR_ZERO);
					ph           = PH_DIGITS;
				end else if (!is_ws) begin
					ph = PH_DONE;
				end
			end else if (ph == PH_DIGITS) begin
				if (is_dig)
					field_acc[f] = 16'(field_acc[f] * 10 + (c - CHAR_ZERO));
				else
					ph = PH_DONE;
			end
			field_ph[f] = ph;
		end
		// position saturates so a long message never restarts a field
		if (msg_pos != POS_MAX)
			msg_pos++;
		if (last) begin
			has_res = 1'b1;
			if (msg_started) begin
				for (int f = 0; f < NUM_FIELDS; f++)
					val[f] = field_neg[f] ? 16'(-field_acc[f]) : field_acc[f];
				same = (val[0] == stored_freq) && (val[1] == stored_ampl) &&
					(val[2] == stored_offs) && (msg_wave == stored_wave) && saved_once;
				res         = make_result(1'b1, !same, msg_wave, val[0], val[1], val[2]);
				stored_wave = msg_wave;
				stored_freq = val[0];
				stored_ampl = val[1];
				stored_offs = val[2];
				saved_once  = 1'b1;
			end
			clear_message();
		end
	endtask

	task automatic note_error(input string msg);
		error_cnt++;
		if (error_cnt <= 10)
			$display("error at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want)
			note_error($sformatf("%s expected %h, got %h", what, want, got));
	endtask

	// one byte transaction; starts and ends at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input cmd_result_t typed_res);
		bit          has_res;
		cmd_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		parse_rx_byte(b, last, has_res, res);
		if (has_res)
			expected_results.push_back(typed ? typed_res : res);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_cmd(input bit typed, input cmd_result_t typed_res);
		for (int i = 0; i < cmd_bytes.size(); i++)
			send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1, typed, typed_res);
		sent_cmds++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] ws_byte();
		int pick;
		pick = $urandom_range(0, 5);
		return (pick == 5) ? CHAR_SPACE : 8'(CHAR_TAB + pick);
	endfunction

	function automatic logic [7:0] wave_letter();
		case ($urandom_range(0, 3))
			0:       return CHAR_TRIANGLE;
			1:       return CHAR_SINE;
			2:       return CHAR_SQUARE;
			default: return CHAR_SAWTOOTH;
		endcase
	endfunction

	// whitespace, optional sign and digits padded out to the given width (the next field start for the first two)
	task automatic add_field(input int width);
		int base;
		int room;
		int ndig;
		base = cmd_bytes.size();
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 2)) cmd_bytes.push_back(ws_byte());
		case ($urandom_range(0, 3))
			0:       cmd_bytes.push_back(CHAR_PLUS);
			1:       cmd_bytes.push_back(CHAR_MINUS);
			default: ;
		endcase
		room = width - (cmd_bytes.size() - base);
		ndig = (room <= 0 || $urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, room);
		repeat (ndig) cmd_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
		while (cmd_bytes.size() - base < width)
			cmd_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : 8'h2C);
	endtask

	task automatic build_random_cmd(input bit force_long);
		int kind;
		int len;
		kind = force_long ? 0 : $urandom_range(1, 100);
		cmd_bytes.delete();
		if (kind <= 1) begin
			len = $urandom_range(256, 300);
			cmd_bytes.push_back(CHAR_START);
			repeat (2) cmd_bytes.push_back(8'($urandom_range(0, 255)));
			cmd_bytes.push_back(wave_letter());
			while (cmd_bytes.size() < len) begin
				kind = $urandom_range(0, 99);
				if (kind < 70)
					cmd_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
				else if (kind < 85)
					cmd_bytes.push_back(CHAR_SPACE);
				else
					cmd_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end else if (kind <= 9 && prev_cmd.size() != 0) begin
			// a repeated message should not count as a change
			cmd_bytes = prev_cmd;
		end else if (kind <= 22) begin
			len = $urandom_range(1, 30);
			cmd_bytes.push_back($urandom_range(0, 1) ? CHAR_START : 8'($urandom_range(0, 255)));
			while (cmd_bytes.size() < len)
				cmd_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (kind <= 28) begin
			cmd_bytes.push_back(CHAR_START);
			repeat ($urandom_range(0, 7)) cmd_bytes.push_back(8'($urandom_range(32, 126)));
		end else begin
			cmd_bytes.push_back(CHAR_START);
			repeat (2) cmd_bytes.push_back(8'($urandom_range(0, 255)));
			cmd_bytes.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) :
				wave_letter());
			repeat (2) cmd_bytes.push_back(8'($urandom_range(0, 255)));
			add_field(POS_AMPL - POS_FREQ);
			add_field(POS_OFFS - POS_AMPL);
			add_field($urandom_range(1, 9));
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, cmd_bytes.size());
				while (cmd_bytes.size() > len)
					void'(cmd_bytes.pop_back());
			end
		end
		prev_cmd = cmd_bytes;
	endtask

	always @(posedge clk) begin
		cmd_result_t got;
		cmd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = cmd_result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				note_error($sformatf("result %h with none expected", m_tdata));
			end else begin
				want = expected_results.pop_front();
				checked_cnt++;
				if (want.ok && !want.changed)
					unchanged_cnt++;
				if (!want.ok)
					rejected_cnt++;
				check_field("message_valid", 16'(want.ok), 16'(got.ok));
				check_field("remote_changed", 16'(want.changed), 16'(got.changed));
				check_field("save_request", 16'(want.save), 16'(got.save));
				check_field("waveform", 16'(want.wave), 16'(got.wave));
				check_field("frequency", want.freq, got.freq);
				check_field("amplitude", want.ampl, got.ampl);
				check_field("offset", want.offs, got.offs);
				check_field("fill", 16'(want.fill), 16'(got.fill));
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		int phase_base;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		clear_message();
		stored_wave = WAVE_TRIANGLE;
		stored_freq = '0;
		stored_ampl = '0;
		stored_offs = '0;
		saved_once  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < NUM_DIR; r++) begin
			cmd_bytes.delete();
			for (int i = 0; i < dir_text[r].len(); i++)
				cmd_bytes.push_back(dir_text[r][i]);
			send_cmd(dir_typed[r], dir_res[r]);
		end
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			phase_base     = sent_bytes;
			while (sent_bytes - phase_base < PHASE_BYTES) begin
				build_random_cmd(p == 1 && sent_bytes == phase_base);
				send_cmd(1'b0, '0);
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("run covered %0d bytes in %0d messages, %0d results checked", sent_bytes,
			sent_cmds, checked_cnt);
		$display("  %0d unchanged repeats, %0d rejected starts, %0d errors", unchanged_cnt,
			rejected_cnt, error_cnt);
		if (error_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
